// ----- rtl/psag_pkg.sv -----
`default_nettype none
package psag_pkg;

  // Size limits of the tensor walk
  localparam int MAX_BATCH    = 16;
  localparam int MAX_DIM      = 256;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_FACTOR   = 8;

  // Register and field widths
  localparam int BATCH_W    = 5;
  localparam int DIM_W      = 9;
  localparam int CHAN_W     = 11;
  localparam int FACTOR_W   = 4;
  localparam int OUT_DIM_W  = 12;
  localparam int BYTE_W     = 8;
  localparam int IDX_W      = 30;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Position counter widths
  localparam int BPOS_W = $clog2(MAX_BATCH);
  localparam int DPOS_W = $clog2(MAX_DIM);
  localparam int CPOS_W = $clog2(MAX_CHANNELS);
  localparam int SUB_W  = $clog2(MAX_FACTOR);

  // Derived size widths
  localparam int RR_W     = 2 * FACTOR_W;
  localparam int OH_W     = DIM_W + FACTOR_W;
  localparam int STRIDE_W = OH_W + CHAN_W;
  localparam int COORD_W  = DPOS_W + FACTOR_W + 1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_BAD_CFG,
    STATUS_CHAN_RANGE
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATCH_COUNT,
    CFG_IN_HEIGHT,
    CFG_IN_WIDTH,
    CFG_IN_CHANNELS,
    CFG_UPSCALE_FACTOR,
    CFG_OUT_HEIGHT,
    CFG_OUT_WIDTH,
    CFG_OUT_CHANNELS
  } cfg_idx_e;

  // Effective sizes and strides seen by the front and back
  typedef struct packed {
    logic [BATCH_W-1:0]  nb;
    logic [DIM_W-1:0]    nh;
    logic [DIM_W-1:0]    nw;
    logic [CHAN_W-1:0]   nc;
    logic [FACTOR_W-1:0] r;
    logic [CHAN_W-1:0]   oc;
    logic                ok;
    logic [STRIDE_W-1:0] stride;
    logic [IDX_W-1:0]    plane;
  } cfg_t;

  // Classified item travelling from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_e           status;
    logic              last;
    logic [BPOS_W-1:0] batch;
    logic [DPOS_W-1:0] row;
    logic [DPOS_W-1:0] col;
    logic [SUB_W-1:0]  sub_h;
    logic [SUB_W-1:0]  sub_w;
    logic [CPOS_W-1:0] cc;
  } item_t;

endpackage
`default_nettype wire

// ----- rtl/pixel_shuffle_address_gen.sv -----
// Pixel shuffle (depth to space) address generator for NHWC tensors.
// Input channel: in_valid_i / in_stall_o with pixel_byte_i, one tensor byte
// per item in NHWC order. Output channel: out_valid_o / out_stall_i with
// dest_index_o, data_byte_o, status_o and last_o, one result per item.
// An item moves when valid is high and stall is low at a rising edge.
// Sizes are written through cfg_we_i / cfg_idx_i / cfg_wdata_i while the
// block is idle; any write restarts the tensor walk at its first element.
// Throughput is one item per cycle while nothing stalls. Each item passes
// through the two-entry queue, then the coordinate, product and sum
// stages of the back pipe, the last being the output reg.
// After reset and after each configuration write the input is stalled
// while the derived strides and size checks are registered.
// While the receiver stalls, the output item holds, the back pipe freezes
// and the queue absorbs up to two items before the input is stalled.
// Status 1 flags a bad factor or size mismatch, status 2 a channel beyond
// the output channel range; both give index zero.
`default_nettype none
module pixel_shuffle_address_gen (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire  [psag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [psag_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [psag_pkg::BYTE_W-1:0]     pixel_byte_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic [psag_pkg::IDX_W-1:0]      dest_index_o,
  output logic [psag_pkg::BYTE_W-1:0]     data_byte_o,
  output logic [psag_pkg::STATUS_W-1:0]   status_o,
  output logic                            last_o
);
  import psag_pkg::*;

  localparam int OCM_W = CHAN_W + RR_W + 1;

  logic [BATCH_W-1:0]   batch_count_q;
  logic [DIM_W-1:0]     in_height_q, in_width_q;
  logic [CHAN_W-1:0]    in_channels_q;
  logic [FACTOR_W-1:0]  upscale_factor_q;
  logic [OUT_DIM_W-1:0] out_height_q, out_width_q;
  logic [CHAN_W-1:0]    out_channels_q;

  logic [BATCH_W-1:0]   nb;
  logic [DIM_W-1:0]     nh, nw;
  logic [CHAN_W-1:0]    nc;
  logic                 r_ok;
  logic [OCM_W-1:0]     oc_lo, oc_hi;
  logic [OH_W+STRIDE_W-1:0] plane_full;

  logic [RR_W-1:0]      rr_q;
  logic [OH_W-1:0]      oh_q, ow_q;
  logic                 ok_q;
  logic [STRIDE_W-1:0]  stride_q;
  logic [IDX_W-1:0]     plane_q;

  cfg_t  cfg;
  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_count_q    <= BATCH_W'(1);
      in_height_q      <= DIM_W'(1);
      in_width_q       <= DIM_W'(1);
      in_channels_q    <= CHAN_W'(1);
      upscale_factor_q <= FACTOR_W'(1);
      out_height_q     <= OUT_DIM_W'(1);
      out_width_q      <= OUT_DIM_W'(1);
      out_channels_q   <= CHAN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BATCH_COUNT:    batch_count_q    <= cfg_wdata_i[BATCH_W-1:0];
        CFG_IN_HEIGHT:      in_height_q      <= cfg_wdata_i[DIM_W-1:0];
        CFG_IN_WIDTH:       in_width_q       <= cfg_wdata_i[DIM_W-1:0];
        CFG_IN_CHANNELS:    in_channels_q    <= cfg_wdata_i[CHAN_W-1:0];
        CFG_UPSCALE_FACTOR: upscale_factor_q <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_OUT_HEIGHT:     out_height_q     <= cfg_wdata_i[OUT_DIM_W-1:0];
        CFG_OUT_WIDTH:      out_width_q      <= cfg_wdata_i[OUT_DIM_W-1:0];
        CFG_OUT_CHANNELS:   out_channels_q   <= cfg_wdata_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes: zero acts as one, oversize acts as the limit
  assign nb = (batch_count_q == '0) ? BATCH_W'(1) :
              (batch_count_q > MAX_BATCH) ? BATCH_W'(MAX_BATCH) : batch_count_q;
  assign nh = (in_height_q == '0) ? DIM_W'(1) :
              (in_height_q > MAX_DIM) ? DIM_W'(MAX_DIM) : in_height_q;
  assign nw = (in_width_q == '0) ? DIM_W'(1) :
              (in_width_q > MAX_DIM) ? DIM_W'(MAX_DIM) : in_width_q;
  assign nc = (in_channels_q == '0) ? CHAN_W'(1) :
              (in_channels_q > MAX_CHANNELS) ? CHAN_W'(MAX_CHANNELS) : in_channels_q;
  assign r_ok = (upscale_factor_q != '0) && (upscale_factor_q <= MAX_FACTOR);

  // Output channels match when oc*rr <= nc < (oc+1)*rr
  assign oc_lo = OCM_W'(out_channels_q) * OCM_W'(rr_q);
  assign oc_hi = (OCM_W'(out_channels_q) + 1'b1) * OCM_W'(rr_q);
  assign plane_full = (OH_W+STRIDE_W)'(oh_q) * (OH_W+STRIDE_W)'(stride_q);

  // Derive strides and the size check over three register stages
  always_ff @(posedge clk_i) begin
    rr_q     <= RR_W'(upscale_factor_q) * RR_W'(upscale_factor_q);
    oh_q     <= OH_W'(nh) * OH_W'(upscale_factor_q);
    ow_q     <= OH_W'(nw) * OH_W'(upscale_factor_q);
    ok_q     <= r_ok && (oh_q == OH_W'(out_height_q)) && (ow_q == OH_W'(out_width_q))
                && (oc_lo <= OCM_W'(nc)) && (OCM_W'(nc) < oc_hi);
    stride_q <= STRIDE_W'(ow_q) * STRIDE_W'(out_channels_q);
    plane_q  <= plane_full[IDX_W-1:0];
  end

  always_comb begin
    cfg.nb     = nb;
    cfg.nh     = nh;
    cfg.nw     = nw;
    cfg.nc     = nc;
    cfg.r      = upscale_factor_q;
    cfg.oc     = out_channels_q;
    cfg.ok     = ok_q;
    cfg.stride = stride_q;
    cfg.plane  = plane_q;
  end

  psag_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .restart_i    (cfg_we_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_byte_i (pixel_byte_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  psag_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .item_o  (pop_item)
  );

  psag_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .empty_i      (empty),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dest_index_o (dest_index_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("input taken right after a configuration write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STATUS_OK)) |-> (dest_index_o == '0))
    else $error("flagged item carries a non-zero index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK || status_o == STATUS_BAD_CFG
                     || status_o == STATUS_CHAN_RANGE))
    else $error("undefined status code on the output");
`endif

endmodule
`default_nettype wire

// ----- rtl/psag_front.sv -----
`default_nettype none
module psag_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire psag_pkg::cfg_t cfg_i,
  input  wire               restart_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [7:0]        pixel_byte_i,
  input  wire               full_i,
  output logic              push_o,
  output psag_pkg::item_t   item_o
);
  import psag_pkg::*;

  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  logic [1:0]        settle_q, settle_d;
  logic [BPOS_W-1:0] batch_q, batch_d;
  logic [DPOS_W-1:0] row_q, row_d;
  logic [DPOS_W-1:0] col_q, col_d;
  logic [CPOS_W-1:0] chan_q, chan_d;
  logic [SUB_W-1:0]  sub_h_q, sub_h_d;
  logic [SUB_W-1:0]  sub_w_q, sub_w_d;
  logic [CPOS_W-1:0] cc_q, cc_d;

  logic [BATCH_W-1:0] batch_nx;
  logic [DIM_W-1:0]   row_nx, col_nx;
  logic [CHAN_W-1:0]  chan_nx;
  logic               chan_wrap, col_wrap, row_wrap, batch_wrap;
  logic               sub_w_wrap, sub_h_wrap;
  status_e            status;

  // Hold off items while sizes settle and while the queue is full
  assign in_stall_o = full_i || (settle_q != '0);
  assign push_o     = in_valid_i && !in_stall_o;

  // Next positions and wrap flags
  assign chan_nx    = CHAN_W'(chan_q) + 1'b1;
  assign col_nx     = DIM_W'(col_q) + 1'b1;
  assign row_nx     = DIM_W'(row_q) + 1'b1;
  assign batch_nx   = BATCH_W'(batch_q) + 1'b1;
  assign chan_wrap  = chan_nx >= cfg_i.nc;
  assign col_wrap   = col_nx >= cfg_i.nw;
  assign row_wrap   = row_nx >= cfg_i.nh;
  assign batch_wrap = batch_nx >= cfg_i.nb;
  assign sub_w_wrap = (FACTOR_W'(sub_w_q) + 1'b1) == cfg_i.r;
  assign sub_h_wrap = (FACTOR_W'(sub_h_q) + 1'b1) == cfg_i.r;

  // Classify the item
  always_comb begin
    if (!cfg_i.ok) begin
      status = STATUS_BAD_CFG;
    end else if (CHAN_W'(cc_q) >= cfg_i.oc) begin
      status = STATUS_CHAN_RANGE;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    item_o.data   = pixel_byte_i;
    item_o.status = status;
    item_o.last   = batch_wrap && row_wrap && col_wrap && chan_wrap;
    item_o.batch  = batch_q;
    item_o.row    = row_q;
    item_o.col    = col_q;
    item_o.sub_h  = sub_h_q;
    item_o.sub_w  = sub_w_q;
    item_o.cc     = cc_q;
  end

  // Advance the tensor walk
  always_comb begin
    settle_d = settle_q;
    batch_d  = batch_q;
    row_d    = row_q;
    col_d    = col_q;
    chan_d   = chan_q;
    sub_h_d  = sub_h_q;
    sub_w_d  = sub_w_q;
    cc_d     = cc_q;
    if (settle_q != '0) begin
      settle_d = settle_q - 1'b1;
    end
    if (restart_i) begin
      settle_d = SETTLE_CYCLES;
      batch_d  = '0;
      row_d    = '0;
      col_d    = '0;
      chan_d   = '0;
      sub_h_d  = '0;
      sub_w_d  = '0;
      cc_d     = '0;
    end else if (push_o) begin
      if (chan_wrap) begin
        chan_d  = '0;
        sub_h_d = '0;
        sub_w_d = '0;
        cc_d    = '0;
        if (col_wrap) begin
          col_d = '0;
          if (row_wrap) begin
            row_d   = '0;
            batch_d = batch_wrap ? '0 : batch_nx[BPOS_W-1:0];
          end else begin
            row_d = row_nx[DPOS_W-1:0];
          end
        end else begin
          col_d = col_nx[DPOS_W-1:0];
        end
      end else begin
        chan_d = chan_nx[CPOS_W-1:0];
        if (sub_w_wrap) begin
          sub_w_d = '0;
          if (sub_h_wrap) begin
            sub_h_d = '0;
            cc_d    = cc_q + 1'b1;
          end else begin
            sub_h_d = sub_h_q + 1'b1;
          end
        end else begin
          sub_w_d = sub_w_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_CYCLES;
      batch_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      chan_q   <= '0;
      sub_h_q  <= '0;
      sub_w_q  <= '0;
      cc_q     <= '0;
    end else begin
      settle_q <= settle_d;
      batch_q  <= batch_d;
      row_q    <= row_d;
      col_q    <= col_d;
      chan_q   <= chan_d;
      sub_h_q  <= sub_h_d;
      sub_w_q  <= sub_w_d;
      cc_q     <= cc_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/psag_fifo.sv -----
`default_nettype none
module psag_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire psag_pkg::item_t item_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output psag_pkg::item_t  item_o
);
  import psag_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign item_o  = mem_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/psag_back.sv -----
`default_nettype none
module psag_back (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire psag_pkg::cfg_t  cfg_i,
  input  wire              empty_i,
  input  wire psag_pkg::item_t item_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [29:0]      dest_index_o,
  output logic [7:0]       data_byte_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  import psag_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    status_e            status;
    logic               last;
    logic [BPOS_W-1:0]  batch;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [CPOS_W-1:0]  cc;
  } coord_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    status_e           status;
    logic              last;
    logic [IDX_W-1:0]  t_batch;
    logic [IDX_W-1:0]  t_row;
    logic [IDX_W-1:0]  t_col;
  } term_t;

  logic             en;
  logic             s1_v_q, s2_v_q, out_v_q;
  coord_t           s1_q, s1_d;
  term_t            s2_q, s2_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [BYTE_W-1:0] data_q;
  status_e          status_q;
  logic             last_q;

  // Advance the whole pipe unless the output holds a stalled item
  assign en    = !out_v_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  // Output row and column
  always_comb begin
    s1_d.data   = item_i.data;
    s1_d.status = item_i.status;
    s1_d.last   = item_i.last;
    s1_d.batch  = item_i.batch;
    s1_d.y      = COORD_W'(item_i.row) * COORD_W'(cfg_i.r) + COORD_W'(item_i.sub_h);
    s1_d.x      = COORD_W'(item_i.col) * COORD_W'(cfg_i.r) + COORD_W'(item_i.sub_w);
    s1_d.cc     = item_i.cc;
  end

  // Strided terms of the linear index
  always_comb begin
    s2_d.data    = s1_q.data;
    s2_d.status  = s1_q.status;
    s2_d.last    = s1_q.last;
    s2_d.t_batch = IDX_W'(s1_q.batch) * cfg_i.plane;
    s2_d.t_row   = IDX_W'(s1_q.y) * IDX_W'(cfg_i.stride);
    s2_d.t_col   = IDX_W'(s1_q.x) * IDX_W'(cfg_i.oc) + IDX_W'(s1_q.cc);
  end

  // Sum the terms; drop the index for flagged items
  assign idx_d = (s2_q.status == STATUS_OK) ?
                 (s2_q.t_batch + s2_q.t_row + s2_q.t_col) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= pop_o;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      idx_q    <= idx_d;
      data_q   <= s2_q.data;
      status_q <= s2_q.status;
      last_q   <= s2_q.last;
    end
  end

  assign out_valid_o  = out_v_q;
  assign dest_index_o = idx_q;
  assign data_byte_o  = data_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule
`default_nettype wire

// ----- dv/pixel_shuffle_address_gen_tb.sv -----
`timescale 1ns / 100ps
module pixel_shuffle_address_gen_tb;
  import psag_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int QUIET_LIMIT  = 2000;

  // One expected result of the address generator
  typedef struct {
    logic [IDX_W-1:0]  dest;
    logic [BYTE_W-1:0] data;
    status_e           status;
    logic              last;
  } dest_entry_t;

  class shuffle_scoreboard;
    logic [BATCH_W-1:0]   batch_count;
    logic [DIM_W-1:0]     in_height;
    logic [DIM_W-1:0]     in_width;
    logic [CHAN_W-1:0]    in_channels;
    logic [FACTOR_W-1:0]  factor;
    logic [OUT_DIM_W-1:0] out_height;
    logic [OUT_DIM_W-1:0] out_width;
    logic [CHAN_W-1:0]    out_channels;
    int unsigned batch_pos, row_pos, col_pos, chan_pos;
    dest_entry_t pending_dests[$];
    int unsigned mismatches, items_in, results_seen, tensor_ends, reg_writes;
    int unsigned status_seen[3];

    function new();
      batch_count  = 1;
      in_height    = 1;
      in_width     = 1;
      in_channels  = 1;
      factor       = 1;
      out_height   = 1;
      out_width    = 1;
      out_channels = 1;
      rewind();
    endfunction

    function void rewind();
      batch_pos = 0;
      row_pos   = 0;
      col_pos   = 0;
      chan_pos  = 0;
    endfunction

    // Zero acts as one, oversize acts as the maximum
    function longint unsigned fit_size(longint unsigned v, longint unsigned mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
    endfunction

    function int unsigned tensor_items();
      return 32'(fit_size(batch_count, MAX_BATCH) * fit_size(in_height, MAX_DIM) *
                 fit_size(in_width, MAX_DIM) * fit_size(in_channels, MAX_CHANNELS));
    endfunction

    function int unsigned pending_count();
      return pending_dests.size();
    endfunction

    // Any register write restarts the tensor walk
    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] wdata);
      case (idx)
        CFG_BATCH_COUNT:    batch_count  = wdata[BATCH_W-1:0];
        CFG_IN_HEIGHT:      in_height    = wdata[DIM_W-1:0];
        CFG_IN_WIDTH:       in_width     = wdata[DIM_W-1:0];
        CFG_IN_CHANNELS:    in_channels  = wdata[CHAN_W-1:0];
        CFG_UPSCALE_FACTOR: factor       = wdata[FACTOR_W-1:0];
        CFG_OUT_HEIGHT:     out_height   = wdata[OUT_DIM_W-1:0];
        CFG_OUT_WIDTH:      out_width    = wdata[OUT_DIM_W-1:0];
        CFG_OUT_CHANNELS:   out_channels = wdata[CHAN_W-1:0];
        default: ;
      endcase
      rewind();
      reg_writes++;
    endfunction

    // Work out the destination of one accepted byte and advance the walk
    function void note_pixel(logic [BYTE_W-1:0] pixel);
      longint unsigned nb, nh, nw, nc, r, rr, oh, ow, oc, cc, sub_h, sub_w, dest;
      dest_entry_t e;
      nb   = fit_size(batch_count, MAX_BATCH);
      nh   = fit_size(in_height, MAX_DIM);
      nw   = fit_size(in_width, MAX_DIM);
      nc   = fit_size(in_channels, MAX_CHANNELS);
      r    = factor;
      dest = 0;
      e.status = STATUS_OK;
      if (r == 0 || r > MAX_FACTOR) begin
        e.status = STATUS_BAD_CFG;
      end else begin
        rr = r * r;
        oh = nh * r;
        ow = nw * r;
        oc = nc / rr;
        if (oh != out_height || ow != out_width || oc != out_channels) begin
          e.status = STATUS_BAD_CFG;
        end else begin
          cc    = chan_pos / rr;
          sub_h = (chan_pos / r) % r;
          sub_w = chan_pos % r;
          if (cc >= oc) begin
            e.status = STATUS_CHAN_RANGE;
          end else begin
            dest = batch_pos * (oh * ow * oc) + (row_pos * r + sub_h) * (ow * oc) +
                   (col_pos * r + sub_w) * oc + cc;
          end
        end
      end
      e.dest = dest[IDX_W-1:0];
      e.data = pixel;
      e.last = (batch_pos + 1 >= nb) && (row_pos + 1 >= nh) &&
               (col_pos + 1 >= nw) && (chan_pos + 1 >= nc);
      pending_dests.push_back(e);
      items_in++;
      // Advance channel, then column, row and batch, wrapping at the end
      chan_pos++;
      if (chan_pos >= nc) begin
        chan_pos = 0;
        col_pos++;
        if (col_pos >= nw) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= nh) begin
            row_pos = 0;
            batch_pos++;
            if (batch_pos >= nb) batch_pos = 0;
          end
        end
      end
    endfunction

    task report_mismatch(string msg);
      $display("%0t MISMATCH %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare a result with the oldest expectation
    task check_result(logic [IDX_W-1:0] dest, logic [BYTE_W-1:0] data,
                      logic [STATUS_W-1:0] status, logic last);
      dest_entry_t e;
      if (pending_dests.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding, dest_index %0d", dest));
        return;
      end
      e = pending_dests.pop_front();
      if (dest !== e.dest)
        report_mismatch($sformatf("result %0d: dest_index %0d, expected %0d",
                                  results_seen, dest, e.dest));
      if (data !== e.data)
        report_mismatch($sformatf("result %0d: data_byte %0d, expected %0d",
                                  results_seen, data, e.data));
      if (status !== e.status)
        report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                  results_seen, status, e.status));
      if (last !== e.last)
        report_mismatch($sformatf("result %0d: last %0b, expected %0b",
                                  results_seen, last, e.last));
      status_seen[int'(e.status)]++;
      if (e.last) tensor_ends++;
      results_seen++;
    endtask
  endclass

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  cfg_idx_e              cfg_idx_i    = CFG_BATCH_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [BYTE_W-1:0]     pixel_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [IDX_W-1:0]      dest_index_o;
  logic [BYTE_W-1:0]     data_byte_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  last_o;

  shuffle_scoreboard sb;
  bit          calm;
  int unsigned random_items;
  int unsigned shape_count;
  int unsigned quiet_cycles;

  pixel_shuffle_address_gen dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_byte_i (pixel_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dest_index_o (dest_index_o),
    .data_byte_o  (data_byte_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // Stall the result side at random outside the calm stretch
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 13);
  end

  // Check each result as it is taken
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(dest_index_o, data_byte_o, status_o, last_o);
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pixel_shuffle_address_gen_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold until taken
  task automatic send_pixel(logic [BYTE_W-1:0] pixel);
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_byte_i <= pixel;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_pixel(pixel);
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic await_results();
    while (sb.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] wdata);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= wdata;
    @(posedge clk_i);
    sb.write_reg(idx, wdata);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Program every register once the block has gone idle
  task automatic load_shape(int unsigned nb, int unsigned nh, int unsigned nw,
                            int unsigned nc, int unsigned r, int unsigned oh,
                            int unsigned ow, int unsigned oc);
    stop_sending();
    await_results();
    write_reg(CFG_BATCH_COUNT, nb);
    write_reg(CFG_IN_HEIGHT, nh);
    write_reg(CFG_IN_WIDTH, nw);
    write_reg(CFG_IN_CHANNELS, nc);
    write_reg(CFG_UPSCALE_FACTOR, r);
    write_reg(CFG_OUT_HEIGHT, oh);
    write_reg(CFG_OUT_WIDTH, ow);
    write_reg(CFG_OUT_CHANNELS, oc);
    shape_count++;
  endtask

  task automatic run_directed();
    // Reset sizes: every byte is a whole tensor
    send_pixel(8'h00);
    send_pixel(8'hFF);
    // Zero batch acts as one; the ninth channel lies beyond the output range
    load_shape(0, 1, 1, 9, 2, 2, 2, 2);
    repeat (9) send_pixel($urandom_range(0, 255));
    // Fewer channels than r squared gives no output channel at all
    load_shape(1, 1, 1, 3, 2, 2, 2, 0);
    send_pixel($urandom_range(0, 255));
    // Factor zero, then a factor above the maximum
    load_shape(1, 1, 1, 1, 0, 0, 0, 0);
    send_pixel($urandom_range(0, 255));
    load_shape(1, 1, 1, 1, 9, 9, 9, 0);
    send_pixel($urandom_range(0, 255));
    // Declared output height does not match
    load_shape(1, 2, 1, 1, 1, 3, 1, 1);
    send_pixel($urandom_range(0, 255));
    // Oversize registers act as their maxima
    load_shape(31, 511, 300, 2047, 1, 256, 256, 1024);
    repeat (2) send_pixel($urandom_range(0, 255));
    // Largest legal shape at the largest factor
    load_shape(16, 256, 256, 1024, 8, 2048, 2048, 16);
    repeat (2) send_pixel($urandom_range(0, 255));
    // A lone register write part way through restarts the walk
    load_shape(1, 2, 2, 2, 1, 2, 2, 2);
    repeat (3) send_pixel($urandom_range(0, 255));
    stop_sending();
    await_results();
    write_reg(CFG_IN_WIDTH, 2);
    repeat (2) send_pixel($urandom_range(0, 255));
  endtask

  // Mostly consistent small shapes, with some broken or odd settings
  task automatic run_random_phase();
    int unsigned nb, nh, nw, nc, r, oh, ow, oc, t, count, pause_at;
    nb = $urandom_range(1, 3);
    nh = $urandom_range(1, 4);
    nw = $urandom_range(1, 4);
    r  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
    nc = r * r * $urandom_range(1, 3);
    if (r > 1 && $urandom_range(0, 3) == 0) nc += $urandom_range(1, r * r - 1);
    oh = nh * r;
    ow = nw * r;
    oc = nc / (r * r);
    case ($urandom_range(0, 19))
      0: r = 0;
      1: r = $urandom_range(9, 15);
      2: oh = oh + 1;
      3: ow = $urandom_range(0, 4095);
      4: oc = oc + $urandom_range(1, 3);
      5: nb = 0;
      6: begin
        nh = $urandom_range(257, 511);
        oh = 256 * r;
      end
      7: begin
        nb = $urandom_range(0, 4095);
        nh = $urandom_range(0, 4095);
        nw = $urandom_range(0, 4095);
        nc = $urandom_range(0, 4095);
        r  = $urandom_range(0, 4095);
        oh = $urandom_range(0, 4095);
        ow = $urandom_range(0, 4095);
        oc = $urandom_range(0, 4095);
      end
      default: ;
    endcase
    load_shape(nb, nh, nw, nc, r, oh, ow, oc);
    t = sb.tensor_items();
    case ($urandom_range(0, 3))
      0, 1:    count = (t <= 200) ? t : $urandom_range(1, 40);
      2:       count = (t <= 100) ? 2 * t + $urandom_range(0, 3) : $urandom_range(1, 60);
      default: count = $urandom_range(1, 12);
    endcase
    pause_at = (shape_count == 10 || $urandom_range(0, 5) == 0) ?
               $urandom_range(1, count) : count + 1;
    for (int unsigned i = 0; i < count && random_items < RANDOM_ITEMS; i++) begin
      if (i == pause_at) begin
        stop_sending();
        await_results();
      end
      calm = (random_items >= 500) && (random_items < 800);
      send_pixel($urandom_range(0, 255));
      random_items++;
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    while (random_items < RANDOM_ITEMS) run_random_phase();
    calm = 1'b0;
    stop_sending();
    await_results();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d items over %0d shapes and %0d register writes.",
             sb.items_in, shape_count, sb.reg_writes);
    $display("Results: %0d mapped, %0d bad config, %0d channel out of range, %0d tensor ends.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.tensor_ends);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("pixel_shuffle_address_gen_tb OK");
    end else begin
      $display("pixel_shuffle_address_gen_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- pixel_shuffle_address_gen.f -----
rtl/psag_pkg.sv
rtl/psag_front.sv
rtl/psag_fifo.sv
rtl/psag_back.sv
rtl/pixel_shuffle_address_gen.sv
dv/pixel_shuffle_address_gen_tb.sv
